// ===== rtl/core/clh_pkg.sv =====
// Shared types and constants for the CAN link handshake block.
`default_nettype none
package clh_pkg;

	localparam int unsigned IdW    = 11;
	localparam int unsigned CountW = 16;
	localparam int unsigned DataW  = 40;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_MODULE_ID         = 3'd0,
		REG_MODULE_TYPE       = 3'd1,
		REG_ANNOUNCE_PERIOD   = 3'd2,
		REG_PRESSURE_PERIOD   = 3'd3,
		REG_ANNOUNCE_FRAME_ID = 3'd4,
		REG_PRESSURE_FRAME_ID = 3'd5,
		REG_RESULT_FRAME_ID   = 3'd6
	} reg_index_t;

	// Reset values of the configuration registers
	localparam logic [CountW-1:0] AnnouncePeriodRst  = 16'd100;
	localparam logic [CountW-1:0] PressurePeriodRst  = 16'd100;
	localparam logic [IdW-1:0]    AnnounceFrameIdRst = 11'h110;
	localparam logic [IdW-1:0]    PressureFrameIdRst = 11'h171;
	localparam logic [IdW-1:0]    ResultFrameIdRst   = 11'h140;

	// Item commands
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_FRAME = 1'b1;

	// Link state codes as reported on the result channel
	localparam logic [1:0] LS_WAITING  = 2'd0;
	localparam logic [1:0] LS_ACCEPTED = 2'd1;
	localparam logic [1:0] LS_REJECTED = 2'd2;

	// Internal link state, one-hot
	typedef enum logic [2:0] {
		LINK_WAITING  = 3'b001,
		LINK_ACCEPTED = 3'b010,
		LINK_REJECTED = 3'b100
	} link_t;

	// Frame lengths and the accept code in result frames
	localparam logic [3:0] DLC_ANNOUNCE = 4'd5;
	localparam logic [3:0] DLC_PRESSURE = 4'd2;
	localparam logic [3:0] DLC_RESULT_MIN = 4'd3;
	localparam logic [7:0] RESULT_ACCEPT = 8'd1;

	// Mailbox indexes
	localparam logic [1:0] MB0 = 2'd0;
	localparam logic [1:0] MB1 = 2'd1;
	localparam logic [1:0] MB2 = 2'd2;

	typedef struct packed {
		logic              command;
		logic [15:0]       pressure;
		logic [2:0]        mailbox_free;
		logic              rx_extended;
		logic              rx_remote;
		logic [IdW-1:0]    rx_std_id;
		logic [3:0]        rx_dlc;
		logic [7:0]        rx_byte0;
		logic [7:0]        rx_byte1;
	} in_item_t;

	typedef struct packed {
		logic              sent;
		logic [1:0]        tx_mailbox;
		logic [IdW-1:0]    tx_std_id;
		logic [3:0]        tx_dlc;
		logic [DataW-1:0]  tx_data;
		logic [1:0]        link_state;
	} out_item_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [31:0] data;
	} cfg_wr_t;

	// Register file contents handed to the link core
	typedef struct packed {
		logic [31:0]       module_id;
		logic [7:0]        module_type;
		logic [CountW-1:0] announce_period;
		logic [CountW-1:0] pressure_period;
		logic [IdW-1:0]    announce_frame_id;
		logic [IdW-1:0]    pressure_frame_id;
		logic [IdW-1:0]    result_frame_id;
	} cfg_regs_t;

endpackage
`default_nettype wire

// ===== rtl/core/clh_chan_if.sv =====
// Valid/ready channel interface with a typed payload.
`default_nettype none
interface clh_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/clh_cfg_regs.sv =====
// Configuration register file of the CAN link handshake block.
`default_nettype none
module clh_cfg_regs
	import clh_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      wr_en,
	input  wire cfg_wr_t   wr,
	output cfg_regs_t      regs
);

	cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.module_id         <= '0;
			regs_q.module_type       <= '0;
			regs_q.announce_period   <= AnnouncePeriodRst;
			regs_q.pressure_period   <= PressurePeriodRst;
			regs_q.announce_frame_id <= AnnounceFrameIdRst;
			regs_q.pressure_frame_id <= PressureFrameIdRst;
			regs_q.result_frame_id   <= ResultFrameIdRst;
		end else if (wr_en) begin
			case (wr.index)
				REG_MODULE_ID:         regs_q.module_id         <= wr.data;
				REG_MODULE_TYPE:       regs_q.module_type       <= wr.data[7:0];
				REG_ANNOUNCE_PERIOD:   regs_q.announce_period   <= wr.data[CountW-1:0];
				REG_PRESSURE_PERIOD:   regs_q.pressure_period   <= wr.data[CountW-1:0];
				REG_ANNOUNCE_FRAME_ID: regs_q.announce_frame_id <= wr.data[IdW-1:0];
				REG_PRESSURE_FRAME_ID: regs_q.pressure_frame_id <= wr.data[IdW-1:0];
				REG_RESULT_FRAME_ID:   regs_q.result_frame_id   <= wr.data[IdW-1:0];
				default: ; // unknown index: write dropped
			endcase
		end
	end

	assign regs = regs_q;

endmodule
`default_nettype wire

// ===== rtl/core/clh_link_core.sv =====
// Link state, elapsed-time counters and frame scheduling for one item.
`default_nettype none
module clh_link_core
	import clh_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire in_item_t  item,
	input  wire logic      commit,
	input  wire cfg_regs_t regs,
	output out_item_t      result
);

	link_t             link_q, link_d;
	logic [CountW-1:0] since_ann_q, since_ann_d;
	logic [CountW-1:0] since_pr_q, since_pr_d;

	logic [CountW-1:0] ann_inc, pr_inc;
	logic              due, have_mb, rx_match;
	logic [1:0]        mb;

	// saturating increments
	assign ann_inc = (since_ann_q == '1) ? since_ann_q : since_ann_q + 1'b1;
	assign pr_inc  = (since_pr_q == '1) ? since_pr_q : since_pr_q + 1'b1;

	// lowest free mailbox
	always_comb begin
		have_mb = 1'b1;
		mb      = MB0;
		if (item.mailbox_free[0]) begin
			mb = MB0;
		end else if (item.mailbox_free[1]) begin
			mb = MB1;
		end else if (item.mailbox_free[2]) begin
			mb = MB2;
		end else begin
			have_mb = 1'b0;
		end
	end

	// dlc clamp to 8 does not change the >= 3 test
	assign rx_match = !item.rx_extended && !item.rx_remote
		&& (item.rx_std_id == regs.result_frame_id)
		&& (item.rx_dlc >= DLC_RESULT_MIN)
		&& (item.rx_byte0 == regs.module_type);

	always_comb begin
		link_d      = link_q;
		since_ann_d = since_ann_q;
		since_pr_d  = since_pr_q;
		due         = 1'b0;
		result      = '0;

		if (item.command == CMD_TICK) begin
			since_ann_d = ann_inc;
			since_pr_d  = pr_inc;
			case (link_q)
				LINK_WAITING: begin
					if (ann_inc >= regs.announce_period) begin
						due         = 1'b1;
						since_ann_d = '0;
						result.tx_std_id = regs.announce_frame_id;
						result.tx_dlc    = DLC_ANNOUNCE;
						result.tx_data   = {regs.module_id, regs.module_type};
					end
				end
				LINK_ACCEPTED: begin
					if (pr_inc >= regs.pressure_period) begin
						due        = 1'b1;
						since_pr_d = '0;
						result.tx_std_id = regs.pressure_frame_id;
						result.tx_dlc    = DLC_PRESSURE;
						result.tx_data   = {{(DataW-16){1'b0}}, item.pressure};
					end
				end
				default: ; // rejected: silent
			endcase
		end else if (rx_match) begin
			link_d = (item.rx_byte1 == RESULT_ACCEPT) ? LINK_ACCEPTED : LINK_REJECTED;
		end

		// counter still cleared when no mailbox is free
		if (due && have_mb) begin
			result.sent       = 1'b1;
			result.tx_mailbox = mb;
		end else begin
			result.tx_std_id = '0;
			result.tx_dlc    = '0;
			result.tx_data   = '0;
		end

		case (link_d)
			LINK_ACCEPTED: result.link_state = LS_ACCEPTED;
			LINK_REJECTED: result.link_state = LS_REJECTED;
			default:       result.link_state = LS_WAITING;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q      <= LINK_WAITING;
			since_ann_q <= '0;
			since_pr_q  <= '0;
		end else if (commit) begin
			link_q      <= link_d;
			since_ann_q <= since_ann_d;
			since_pr_q  <= since_pr_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/can_module_link_handshake.sv =====
// Top level of the CAN node link handshake block.
//
// Channels (valid/ready, a transaction moves when both are high):
//   items   - one tick (1 ms elapsed plus a pressure sample) or one received
//             frame, with the current mailbox_free mask.
//   results - exactly one result per item: the frame placed into a transmit
//             mailbox (if any) and the link state after the item.
//   cfg     - register writes (index, data); always ready. Write only while
//             the block is idle. Unknown indexes are dropped.
// Path: an item is captured in the input register, evaluated against the
// link state and counters, and lands in the result register, which drives
// the results channel.
// Throughput: one item per cycle while results are drained; the link state
// and both counters update in the same cycle the item moves into the result
// register, so a following item already sees them.
// Stall: while the result register is held, one more item is taken into the
// input register; after that items.ready drops until results are drained.
// Reset (arst_n low): link waiting, counters zero, registers to defaults,
// both pipeline stages empty.
`default_nettype none
module can_module_link_handshake
	import clh_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	clh_chan_if.sink   items,
	clh_chan_if.source results,
	clh_chan_if.sink   cfg
);

	cfg_regs_t regs;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t result_s2;
	logic      valid_s2;
	out_item_t result;
	logic      advance;
	logic      load;

	// configuration is always taken
	assign cfg.ready = 1'b1;

	clh_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg.valid),
		.wr     (cfg.data),
		.regs   (regs)
	);

	// the result register can take a new value when empty or being drained
	assign advance     = !valid_s2 || results.ready;
	assign items.ready = !valid_s1 || advance;
	assign load        = items.valid && items.ready;

	// the item in stage 1 commits its state update as it moves forward
	clh_link_core u_link_core (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.commit (valid_s1 && advance),
		.regs   (regs),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= items.data;
		end
		if (advance && valid_s1) begin
			result_s2 <= result;
		end
	end

	assign results.valid = valid_s2;
	assign results.data  = result_s2;

endmodule
`default_nettype wire
